@@ hdl/dvt_pkg.sv @@
package dvt_pkg;

    localparam int SLOT_BITS     = 6;
    localparam int SLOT_COUNT    = 2 ** SLOT_BITS;
    localparam int LANE_COUNT    = 8;
    localparam int EXPONENT_BITS = 8;
    localparam int WORD_BITS     = 64;

    localparam int USED_LANES = (LANE_COUNT * EXPONENT_BITS <= WORD_BITS) ?
                                LANE_COUNT : WORD_BITS / EXPONENT_BITS;
    localparam int USED_BITS  = USED_LANES * EXPONENT_BITS;

    localparam logic [WORD_BITS-1:0] USED_MASK = (USED_BITS >= WORD_BITS) ?
        {WORD_BITS{1'b1}} : ((WORD_BITS'(1) << USED_BITS) - WORD_BITS'(1));

    localparam logic signed [EXPONENT_BITS:0] LANE_LIMIT =
        (EXPONENT_BITS + 1)'((2 ** (EXPONENT_BITS - 1)) - 1);

    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_PRODUCT  = 3'd1;
    localparam logic [2:0] MODE_QUOTIENT = 3'd2;
    localparam logic [2:0] MODE_DELETE   = 3'd3;
    localparam logic [2:0] MODE_READ     = 3'd4;
    localparam logic [2:0] MODE_CHECK    = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    typedef struct packed {
        logic [2:0]           mode;
        logic [SLOT_BITS-1:0] slot_a;
        logic [SLOT_BITS-1:0] slot_b;
        logic [WORD_BITS-1:0] vector_in;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [SLOT_BITS-1:0] slot_out;
        logic [WORD_BITS-1:0] vector_out;
        logic                 differs;
        logic                 saturated;
    } rsp_t;

endpackage

@@ hdl/dvt_ram.sv @@
module dvt_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [dvt_pkg::SLOT_BITS-1:0] waddr,
    input  logic [dvt_pkg::WORD_BITS-1:0] wdata,
    input  logic                          ren,
    input  logic [dvt_pkg::SLOT_BITS-1:0] raddr_a,
    input  logic [dvt_pkg::SLOT_BITS-1:0] raddr_b,
    output logic [dvt_pkg::WORD_BITS-1:0] rdata_a,
    output logic [dvt_pkg::WORD_BITS-1:0] rdata_b
);
    import dvt_pkg::*;

    logic [WORD_BITS-1:0] mem [SLOT_COUNT];
    logic [WORD_BITS-1:0] rdata_a_reg;
    logic [WORD_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // forward a same-cycle write to the read ports
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_a_reg <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
            rdata_b_reg <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hdl/dvt_lanes.sv @@
module dvt_lanes (
    input  logic [dvt_pkg::WORD_BITS-1:0] a,
    input  logic [dvt_pkg::WORD_BITS-1:0] b,
    input  logic                          sub,
    output logic [dvt_pkg::WORD_BITS-1:0] result,
    output logic                          sat
);
    import dvt_pkg::*;

    always_comb
    begin
        logic signed [EXPONENT_BITS:0] x;
        logic signed [EXPONENT_BITS:0] y;
        logic signed [EXPONENT_BITS:0] z;
        result = '0;
        sat    = 1'b0;
        for (int k = 0; k < USED_LANES; k++)
        begin
            x = {a[k*EXPONENT_BITS+EXPONENT_BITS-1], a[k*EXPONENT_BITS +: EXPONENT_BITS]};
            y = {b[k*EXPONENT_BITS+EXPONENT_BITS-1], b[k*EXPONENT_BITS +: EXPONENT_BITS]};
            z = sub ? (x - y) : (x + y);
            // clamp to the symmetric lane range
            if (z > LANE_LIMIT)
            begin
                z   = LANE_LIMIT;
                sat = 1'b1;
            end
            else if (z < -LANE_LIMIT)
            begin
                z   = -LANE_LIMIT;
                sat = 1'b1;
            end
            result[k*EXPONENT_BITS +: EXPONENT_BITS] = z[EXPONENT_BITS-1:0];
        end
    end

endmodule

@@ hdl/dimension_vector_table_top.sv @@
// A request and its two-port table read are registered on acceptance; the response
// register loads when the execute stage runs. Throughput: one transaction per cycle
// unless a response stalls; a single execute stage updates occupancy and the table.
// Reset: asynchronous, clears slot occupancy and all pipeline valids;
// table contents are not cleared.
module dimension_vector_table_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dvt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dvt_pkg::rsp_t rsp
);
    import dvt_pkg::*;

    logic                  s0_valid_reg;
    logic                  s0_valid_next;
    req_t                  s0_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic [SLOT_COUNT-1:0] in_use_reg;
    logic [SLOT_COUNT-1:0] in_use_next;

    logic                  res_free;
    logic                  exec;
    logic                  accept;
    logic [WORD_BITS-1:0]  rd_a;
    logic [WORD_BITS-1:0]  rd_b;
    logic [WORD_BITS-1:0]  lane_sum;
    logic                  lane_sat;
    logic                  ok_a;
    logic                  ok_b;
    logic [SLOT_BITS-1:0]  free_idx;
    logic                  full;
    logic                  we;
    logic [WORD_BITS-1:0]  wdata;

    assign res_free  = !rsp_valid_reg || !rsp_stall;
    assign exec      = s0_valid_reg && res_free;
    assign req_stall = s0_valid_reg && !res_free;
    assign accept    = req_valid && !req_stall;

    dvt_ram u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (free_idx),
        .wdata   (wdata),
        .ren     (accept),
        .raddr_a (req.slot_a),
        .raddr_b (req.slot_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    dvt_lanes u_lanes (
        .a      (rd_a),
        .b      (rd_b),
        .sub    (s0_reg.mode == MODE_QUOTIENT),
        .result (lane_sum),
        .sat    (lane_sat)
    );

    assign ok_a = in_use_reg[s0_reg.slot_a];
    assign ok_b = in_use_reg[s0_reg.slot_b];
    assign full = &in_use_reg;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        rsp_next    = '0;
        in_use_next = in_use_reg;
        we          = 1'b0;
        wdata       = (s0_reg.mode == MODE_INSERT) ? (s0_reg.vector_in & USED_MASK) : lane_sum;
        unique case (s0_reg.mode)
            MODE_INSERT, MODE_PRODUCT, MODE_QUOTIENT:
            begin
                if ((s0_reg.mode != MODE_INSERT) && !(ok_a && ok_b))
                begin
                    rsp_next.status = ST_FREE;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    we                    = exec;
                    in_use_next[free_idx] = 1'b1;
                    rsp_next.slot_out     = free_idx;
                    rsp_next.saturated    = (s0_reg.mode != MODE_INSERT) && lane_sat;
                end
            end
            MODE_DELETE:
            begin
                if (!ok_a)
                begin
                    rsp_next.status = ST_FREE;
                end
                else
                begin
                    in_use_next[s0_reg.slot_a] = 1'b0;
                end
            end
            MODE_READ:
            begin
                if (!ok_a)
                begin
                    rsp_next.status = ST_FREE;
                end
                else
                begin
                    rsp_next.vector_out = rd_a;
                end
            end
            MODE_CHECK:
            begin
                if (!(ok_a && ok_b))
                begin
                    rsp_next.status = ST_FREE;
                end
                else
                begin
                    rsp_next.differs = (rd_a != rd_b);
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (accept)
        begin
            s0_valid_next = 1'b1;
        end
        else if (exec)
        begin
            s0_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            in_use_reg    <= '0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec)
            begin
                in_use_reg <= in_use_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_reg <= req;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hdl/dvt_chk.sv @@
module dvt_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input dvt_pkg::rsp_t rsp
);
    import dvt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK) || (rsp.status == ST_FULL) ||
                      (rsp.status == ST_FREE))
        else $error("undefined status");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |->
            (rsp.slot_out == '0) && (rsp.vector_out == '0) && !rsp.differs && !rsp.saturated)
        else $error("error response carries data");

    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.vector_out != '0) |->
            (rsp.slot_out == '0) && !rsp.differs && !rsp.saturated)
        else $error("read response mixed with other results");

    a_diff_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.differs |-> (rsp.slot_out == '0) && !rsp.saturated)
        else $error("check response mixed with allocation");

endmodule

bind dimension_vector_table_top dvt_chk u_dvt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

@@ verif/dimension_vector_table_top_test.sv @@
module dimension_vector_table_top_test;

    import dvt_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    dimension_vector_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic                 slot_busy [SLOT_COUNT];
    logic [WORD_BITS-1:0] stored_vec [SLOT_COUNT];

    req_t ops_to_send [$];
    rsp_t table_replies [$];
    rsp_t want;

    int  issued = 0;
    int  accepted = 0;
    int  awaiting = 0;
    int  mismatches = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  req_taken = 1'b0;
    bit  calm = 1'b0;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int lowest_free();
        int i;
        for (i = 0; i < SLOT_COUNT; i++)
            if (!slot_busy[i])
                return i;
        return -1;
    endfunction

    function automatic logic [WORD_BITS-1:0] lane_combine(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] y,
        input logic                 minus,
        output logic                clipped
    );
        logic [WORD_BITS-1:0] w;
        int lx;
        int ly;
        int lz;
        int lim;
        int k;
        lim = (1 << (EXPONENT_BITS - 1)) - 1;
        w = '0;
        clipped = 1'b0;
        for (k = 0; k < USED_LANES; k++)
        begin
            lx = int'($signed(x[k*EXPONENT_BITS +: EXPONENT_BITS]));
            ly = int'($signed(y[k*EXPONENT_BITS +: EXPONENT_BITS]));
            lz = minus ? lx - ly : lx + ly;
            if (lz > lim)
            begin
                lz = lim;
                clipped = 1'b1;
            end
            if (lz < -lim)
            begin
                lz = -lim;
                clipped = 1'b1;
            end
            w[k*EXPONENT_BITS +: EXPONENT_BITS] = lz[EXPONENT_BITS-1:0];
        end
        return w;
    endfunction

    function automatic rsp_t apply_table_op(input req_t r);
        rsp_t o;
        logic [WORD_BITS-1:0] word;
        logic clipped;
        int spot;
        o = '0;
        word = r.vector_in & USED_MASK;
        clipped = 1'b0;
        case (r.mode)
            MODE_INSERT, MODE_PRODUCT, MODE_QUOTIENT:
            begin
                if (r.mode != MODE_INSERT && !(slot_busy[r.slot_a] && slot_busy[r.slot_b]))
                begin
                    o.status = ST_FREE;
                end
                else
                begin
                    if (r.mode != MODE_INSERT)
                        word = lane_combine(stored_vec[r.slot_a], stored_vec[r.slot_b],
                                            r.mode == MODE_QUOTIENT, clipped);
                    spot = lowest_free();
                    if (spot < 0)
                    begin
                        o.status = ST_FULL;
                    end
                    else
                    begin
                        slot_busy[spot] = 1'b1;
                        stored_vec[spot] = word;
                        o.slot_out = spot[SLOT_BITS-1:0];
                        o.saturated = clipped;
                    end
                end
            end
            MODE_DELETE:
            begin
                if (!slot_busy[r.slot_a])
                    o.status = ST_FREE;
                else
                    slot_busy[r.slot_a] = 1'b0;
            end
            MODE_READ:
            begin
                if (!slot_busy[r.slot_a])
                    o.status = ST_FREE;
                else
                    o.vector_out = stored_vec[r.slot_a];
            end
            MODE_CHECK:
            begin
                if (!(slot_busy[r.slot_a] && slot_busy[r.slot_b]))
                    o.status = ST_FREE;
                else
                    o.differs = stored_vec[r.slot_a] != stored_vec[r.slot_b];
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // drive one transaction at a time; sending waits on acceptance, not on the response
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (ops_to_send.size() > 0)
            begin
                req <= ops_to_send.pop_front();
                req_valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken = 1'b0;
        end
        else
        begin
            req_taken = req_valid && !req_stall;
            if (req_taken)
            begin
                table_replies.push_back(apply_table_op(req));
                accepted++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (table_replies.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected transaction: st %0d slot %0d vec %h diff %b sat %b",
                                 rsp.status, rsp.slot_out, rsp.vector_out, rsp.differs,
                                 rsp.saturated);
                    mismatches++;
                end
                else
                begin
                    want = table_replies.pop_front();
                    if (rsp.status !== want.status || rsp.slot_out !== want.slot_out ||
                        rsp.vector_out !== want.vector_out || rsp.differs !== want.differs ||
                        rsp.saturated !== want.saturated)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch: expected st %0d slot %0d vec %h diff %b sat %b",
                                     want.status, want.slot_out, want.vector_out, want.differs,
                                     want.saturated);
                            $display("          actual   st %0d slot %0d vec %h diff %b sat %b",
                                     rsp.status, rsp.slot_out, rsp.vector_out, rsp.differs,
                                     rsp.saturated);
                        end
                        mismatches++;
                    end
                end
            end
            awaiting = table_replies.size();
        end
    end

    task automatic send_op(
        input logic [2:0]           m,
        input logic [SLOT_BITS-1:0] a,
        input logic [SLOT_BITS-1:0] b,
        input logic [WORD_BITS-1:0] v
    );
        req_t item;
        item.mode = m;
        item.slot_a = a;
        item.slot_b = b;
        item.vector_in = v;
        ops_to_send.push_back(item);
        issued++;
        wait (accepted == issued);
    endtask

    function automatic logic [SLOT_BITS-1:0] busy_slot();
        int list [$];
        int i;
        for (i = 0; i < SLOT_COUNT; i++)
            if (slot_busy[i])
                list.push_back(i);
        if (list.size() == 0)
            return SLOT_BITS'($urandom_range(0, SLOT_COUNT - 1));
        return SLOT_BITS'(list[$urandom_range(0, list.size() - 1)]);
    endfunction

    function automatic logic [WORD_BITS-1:0] make_vector();
        logic [WORD_BITS-1:0] v;
        int r;
        int k;
        r = $urandom_range(0, 9);
        if (r == 0)
            return {$urandom, $urandom};
        if (r == 1)
            return stored_vec[busy_slot()];
        for (k = 0; k < WORD_BITS / 8; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                v[k*8 +: 8] = 8'($urandom);
            else if (r < 7)
                v[k*8 +: 8] = 8'($urandom_range(0, 16) - 8);
            else if (r == 7)
                v[k*8 +: 8] = 8'h7f;
            else if (r == 8)
                v[k*8 +: 8] = $urandom_range(0, 1) ? 8'h80 : 8'h81;
            else
                v[k*8 +: 8] = 8'h00;
        end
        return v;
    endfunction

    task automatic random_op(input bit filling);
        int pick;
        logic [2:0] m;
        logic [SLOT_BITS-1:0] a;
        logic [SLOT_BITS-1:0] b;
        logic [WORD_BITS-1:0] v;
        pick = $urandom_range(0, 99);
        v = make_vector();
        a = busy_slot();
        b = busy_slot();
        if (pick >= 94)
            m = 3'($urandom_range(0, 7));
        else if (filling)
            m = pick < 35 ? MODE_INSERT : pick < 55 ? MODE_PRODUCT :
                pick < 75 ? MODE_QUOTIENT : pick < 82 ? MODE_DELETE :
                pick < 88 ? MODE_READ : MODE_CHECK;
        else
            m = pick < 5 ? MODE_INSERT : pick < 8 ? MODE_PRODUCT :
                pick < 11 ? MODE_QUOTIENT : pick < 70 ? MODE_DELETE :
                pick < 82 ? MODE_READ : MODE_CHECK;
        if (pick >= 94 || $urandom_range(0, 9) == 0)
        begin
            a = SLOT_BITS'($urandom_range(0, SLOT_COUNT - 1));
            b = SLOT_BITS'($urandom_range(0, SLOT_COUNT - 1));
        end
        if (m == MODE_CHECK && $urandom_range(0, 3) == 0)
            b = a;
        send_op(m, a, b, v);
    endtask

    initial
    begin
        int round;
        int n;
        for (n = 0; n < SLOT_COUNT; n++)
        begin
            slot_busy[n] = 1'b0;
            stored_vec[n] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_op(MODE_CHECK, 0, 0, '0);
        send_op(MODE_READ, 0, 0, '0);
        send_op(MODE_DELETE, 5, 0, '0);
        send_op(MODE_PRODUCT, 0, 1, '0);
        send_op(MODE_INSERT, 0, 0, {WORD_BITS{1'b1}});
        send_op(MODE_INSERT, 0, 0, {8{8'h7f}});
        send_op(MODE_INSERT, 0, 0, {8{8'h80}});
        send_op(MODE_INSERT, 63, 63, '0);
        send_op(MODE_INSERT, 0, 0, {8{8'h81}});
        send_op(MODE_PRODUCT, 1, 1, '0);
        send_op(MODE_QUOTIENT, 4, 1, '0);
        send_op(MODE_PRODUCT, 2, 3, '0);
        send_op(MODE_QUOTIENT, 3, 2, '0);
        send_op(MODE_PRODUCT, 0, 3, '0);
        send_op(MODE_QUOTIENT, 1, 1, '0);
        send_op(MODE_READ, 2, 0, '0);
        send_op(MODE_READ, 7, 0, '0);
        send_op(MODE_CHECK, 1, 1, '0);
        send_op(MODE_CHECK, 0, 9, '0);
        send_op(MODE_CHECK, 0, 1, '0);
        send_op(MODE_DELETE, 3, 0, '0);
        send_op(MODE_READ, 3, 0, '0);
        send_op(MODE_INSERT, 0, 0, 64'h0123456789abcdef);
        send_op(3'd6, 6'h2a, 6'h15, {$urandom, $urandom});
        send_op(3'd7, 6'h15, 6'h2a, {$urandom, $urandom});

        // hold until the table has answered everything
        wait (awaiting == 0);

        for (round = 0; round < 4; round++)
        begin
            for (n = 0; n < 210; n++)
            begin
                if (n % 50 == 0)
                    calm = $urandom_range(0, 3) == 0;
                if ($urandom_range(0, 49) == 0)
                    wait (awaiting == 0);
                random_op(n < 130);
            end
        end
        calm = 1'b0;

        wait (awaiting == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
